FILE: hw/rtl/nearest_center_region_labeler_assert.svh
// Assertion macros shared by the labeler's modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef NEAREST_CENTER_REGION_LABELER_ASSERT_SVH
`define NEAREST_CENTER_REGION_LABELER_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define NCRL_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define NCRL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define NCRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/ncrl_pkg.sv
// Package for the nearest-center region labeler: widths, codes and the
// transfer and chain token types. No dependencies.
package ncrl_pkg;

  // Coordinate formats: pixels are integers, centers are unsigned Q10.8.
  localparam int COORD_BITS  = 10;
  localparam int FRAC_BITS   = 8;
  localparam int CENTER_BITS = COORD_BITS + FRAC_BITS;
  localparam int SQ_W        = 2 * CENTER_BITS;
  // A sum of three squares stays below 2^(SQ_W+2).
  localparam int DIST_W      = SQ_W + 2;

  localparam int SLOT_W      = 4;
  localparam int REGION_W    = 4;
  localparam int MASK_W      = 16;
  localparam int NUM_W       = 5;

  localparam int MAX_CENTERS_DEF = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CENTERS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_THREE_D     = 1'b1;

  // Command codes.
  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  typedef struct packed {
    logic                   command;
    logic [SLOT_W-1:0]      center_index;
    logic [CENTER_BITS-1:0] center_x;
    logic [CENTER_BITS-1:0] center_y;
    logic [CENTER_BITS-1:0] center_z;
    logic [COORD_BITS-1:0]  pixel_x;
    logic [COORD_BITS-1:0]  pixel_y;
    logic [COORD_BITS-1:0]  pixel_z;
  } in_item_t;

  typedef struct packed {
    logic [REGION_W-1:0] nearest_region;
    logic [MASK_W-1:0]   region_mask;
  } out_item_t;

  // What travels from cell to cell: the item, the configuration seen at
  // acceptance, and the best match found so far.
  typedef struct packed {
    in_item_t            item;
    logic [NUM_W-1:0]    num_centers;
    logic                three_d;
    logic [DIST_W-1:0]   best_d;
    logic [REGION_W-1:0] best_i;
  } ncrl_token_t;

endpackage

FILE: hw/rtl/ncrl_cell.sv
// One cell of the labeler chain: holds one center and compares it with
// each pixel that passes. Depends on ncrl_pkg and the assertion header.
`include "nearest_center_region_labeler_assert.svh"

module ncrl_cell import ncrl_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  ncrl_token_t in_tok,
  output logic        out_valid,
  output ncrl_token_t out_tok
);

  // Stored center of this slot.
  logic [CENTER_BITS-1:0] cx_r, cy_r, cz_r;

  // Stage 1: token and squared differences.
  logic                   s1_valid_r;
  ncrl_token_t            s1_tok_r;
  logic [SQ_W-1:0]        sq_x_r, sq_y_r, sq_z_r;
  logic [SQ_W-1:0]        sq_x_nxt, sq_y_nxt, sq_z_nxt;

  // Stage 2: token with the updated best match.
  logic                   s2_valid_r;
  ncrl_token_t            s2_tok_r;
  ncrl_token_t            s2_tok_nxt;

  logic                   load_hit;
  logic [CENTER_BITS-1:0] px, py, pz;
  logic [CENTER_BITS-1:0] dx, dy, dz;
  logic [DIST_W-1:0]      d_sum;
  logic                   in_range;
  logic                   take;

  // A load claims this slot when its index matches; loads travel the chain
  // in order with classify items, so each pixel sees exactly the loads
  // accepted before it.
  assign load_hit = in_valid && (in_tok.item.command == CMD_LOAD) &&
                    (32'(in_tok.item.center_index) == CELL_IDX);

  always_ff @(posedge clk) begin
    if (load_hit) begin
      cx_r <= in_tok.item.center_x;
      cy_r <= in_tok.item.center_y;
      cz_r <= in_tok.item.center_z;
    end
  end

  // Absolute differences in Q.8 units, then squares. The z term drops out
  // in 2D mode.
  always_comb begin
    px = {in_tok.item.pixel_x, {FRAC_BITS{1'b0}}};
    py = {in_tok.item.pixel_y, {FRAC_BITS{1'b0}}};
    pz = {in_tok.item.pixel_z, {FRAC_BITS{1'b0}}};
    dx = (px >= cx_r) ? (px - cx_r) : (cx_r - px);
    dy = (py >= cy_r) ? (py - cy_r) : (cy_r - py);
    dz = (pz >= cz_r) ? (pz - cz_r) : (cz_r - pz);
    if (!in_tok.three_d) begin
      dz = '0;
    end
    sq_x_nxt = SQ_W'(dx) * SQ_W'(dx);
    sq_y_nxt = SQ_W'(dy) * SQ_W'(dy);
    sq_z_nxt = SQ_W'(dz) * SQ_W'(dz);
  end

  // Stage 1 payload.
  always_ff @(posedge clk) begin
    s1_tok_r <= in_tok;
    sq_x_r   <= sq_x_nxt;
    sq_y_r   <= sq_y_nxt;
    sq_z_r   <= sq_z_nxt;
  end

  // Sum and compare. Slot 0 always sets the first match; later slots take
  // over only on a strictly smaller distance, so ties keep the lower index.
  always_comb begin
    d_sum    = DIST_W'(sq_x_r) + DIST_W'(sq_y_r) + DIST_W'(sq_z_r);
    in_range = (32'(s1_tok_r.num_centers) > CELL_IDX);
    take     = (CELL_IDX == 0) || (in_range && (d_sum < s1_tok_r.best_d));
    s2_tok_nxt = s1_tok_r;
    if ((s1_tok_r.item.command == CMD_CLASSIFY) && take) begin
      s2_tok_nxt.best_d = d_sum;
      s2_tok_nxt.best_i = REGION_W'(CELL_IDX);
    end
  end

  always_ff @(posedge clk) begin
    s2_tok_r <= s2_tok_nxt;
  end

  // Valid bits of both stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_tok   = s2_tok_r;

  // The chain never holds a token back.
  `NCRL_ASSERT_NEXT(a_cell_advance, s1_valid_r, s2_valid_r, "cell dropped a token")
  // The first cell always names itself as the current best.
  `NCRL_ASSERT_SAME(a_cell_first, (CELL_IDX == 0) && s2_valid_r && (s2_tok_r.item.command == CMD_CLASSIFY), s2_tok_r.best_i == '0, "first cell did not seed the best match")
  // Past the first cell, the best distance can only shrink.
  `NCRL_ASSERT_SAME(a_cell_monotone, (CELL_IDX != 0) && s2_valid_r && (s2_tok_r.item.command == CMD_CLASSIFY), s2_tok_r.best_d <= $past(s1_tok_r.best_d), "best distance grew")

endmodule

FILE: hw/rtl/nearest_center_region_labeler.sv
// Top level of the nearest-center region labeler: configuration registers,
// the chain of center cells and the result register. Depends on ncrl_pkg,
// ncrl_cell and the assertion header.
//
// The block takes one item per clock cycle (busy stays low), and a classify
// item passes down the whole chain of cells to reach the outputs: each of
// the MAX_CENTERS cells adds two register stages (square, then sum and
// compare) and one more register drives the outputs. Load items move down
// the same chain, so a classify sees every load accepted before it and none
// after it. Results appear on out_item for one cycle with out_valid high and
// cannot be stalled; a load produces no result. Configuration writes take
// effect for items accepted after the write.
`include "nearest_center_region_labeler_assert.svh"

module nearest_center_region_labeler import ncrl_pkg::*; #(
  parameter int MAX_CENTERS = MAX_CENTERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  out_valid,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [NUM_W-1:0] num_centers_r;
  logic             three_d_r;

  logic             chain_vld [MAX_CENTERS+1];
  ncrl_token_t      chain_tok [MAX_CENTERS+1];

  logic             out_valid_r;
  out_item_t        out_item_r;

  // The chain accepts a new item every cycle.
  assign busy = 1'b0;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_centers_r <= NUM_W'(1);
      three_d_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_CENTERS: num_centers_r <= cfg_wdata[NUM_W-1:0];
        CFG_THREE_D:     three_d_r     <= cfg_wdata[0];
      endcase
    end
  end

  // Token entering the chain on each accepted transfer.
  always_comb begin
    chain_vld[0]             = start && !busy;
    chain_tok[0].item        = in_item;
    chain_tok[0].num_centers = num_centers_r;
    chain_tok[0].three_d     = three_d_r;
    chain_tok[0].best_d      = '0;
    chain_tok[0].best_i      = '0;
  end

  // One cell per center slot.
  for (genvar g = 0; g < MAX_CENTERS; g++) begin : g_cell
    ncrl_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_vld[g]),
      .in_tok    (chain_tok[g]),
      .out_valid (chain_vld[g+1]),
      .out_tok   (chain_tok[g+1])
    );
  end

  // Result register: classify items leave the chain as a one-cycle strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain_vld[MAX_CENTERS] &&
                     (chain_tok[MAX_CENTERS].item.command == CMD_CLASSIFY);
    end
  end

  always_ff @(posedge clk) begin
    out_item_r.nearest_region <= chain_tok[MAX_CENTERS].best_i;
    out_item_r.region_mask    <= MASK_W'(1) << chain_tok[MAX_CENTERS].best_i;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // The mask marks exactly the reported region.
  `NCRL_ASSERT_SAME(a_mask_onehot, out_valid_r, $onehot(out_item_r.region_mask), "region mask not one-hot")
  `NCRL_ASSERT_SAME(a_mask_match, out_valid_r, out_item_r.region_mask[out_item_r.nearest_region], "mask bit does not match region")
  // A load leaving the chain never produces a result.
  `NCRL_ASSERT_NEXT(a_load_silent, chain_vld[MAX_CENTERS] && (chain_tok[MAX_CENTERS].item.command == CMD_LOAD), !out_valid_r, "load produced a result")

endmodule
